>>> rtl/core/cfp_pkg.sv
// Shared types, codes and helpers for the command frame parser.
`default_nettype none

package cfp_pkg;

  // Framing bytes
  localparam logic [7:0] HEAD_BYTE   = 8'hAA;
  localparam logic [7:0] TAIL_BYTE   = 8'hFF;
  localparam logic [7:0] TYPE_TASK   = 8'h10;
  localparam logic [7:0] TYPE_TARGET = 8'h11;
  localparam logic [7:0] TYPE_RECOG  = 8'h12;
  localparam logic [7:0] TYPE_POS    = 8'h13;

  // Internal frame type codes
  localparam logic [2:0] FT_NONE   = 3'd0;
  localparam logic [2:0] FT_TASK   = 3'd1;
  localparam logic [2:0] FT_TARGET = 3'd2;
  localparam logic [2:0] FT_RECOG  = 3'd3;
  localparam logic [2:0] FT_POS    = 3'd4;

  // Byte positions inside a frame
  localparam logic [2:0] POS_HEAD    = 3'd0;
  localparam logic [2:0] POS_TYPE    = 3'd1;
  localparam logic [2:0] POS_PAYLOAD = 3'd2;

  localparam int unsigned PAYLOAD_DEPTH = 5;
  localparam logic [15:0] Y_OFFSET_RESET = 16'd30;

  // Output word width: 58 bits of fields padded to 64
  localparam int unsigned OUT_DATA_W = 64;

  // One decoded frame
  typedef struct packed {
    logic [1:0]         frame_kind;
    logic [7:0]         first_value;
    logic [7:0]         target_first;
    logic [7:0]         target_second;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } res_t;

  // Position of the tail byte for a frame type; zero when there is no frame
  function automatic logic [2:0] tail_pos(input logic [2:0] ft);
    logic [2:0] tp;
    unique case (ft)
      FT_TASK:   tp = 3'd3;
      FT_TARGET: tp = 3'd5;
      FT_RECOG:  tp = 3'd3;
      FT_POS:    tp = 3'd7;
      default:   tp = 3'd0;
    endcase
    return tp;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cfp_parser.sv
// Frame parser: position counter, frame type, payload bytes and result decode.
`default_nettype none

module cfp_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_take,
  input  wire logic [7:0]       in_byte,
  input  wire logic [15:0]      y_offset,
  output logic                  res_valid,
  output cfp_pkg::res_t         res
);

  logic [2:0] byte_position, byte_position_next;
  logic [2:0] frame_type, frame_type_next;
  logic [7:0] payload_store [cfp_pkg::PAYLOAD_DEPTH];
  logic [2:0] tail;
  logic       pay_we;
  logic [2:0] pay_idx;
  logic [15:0] y_raw;

  assign tail    = cfp_pkg::tail_pos(frame_type);
  assign pay_idx = byte_position - cfp_pkg::POS_PAYLOAD;
  assign y_raw   = {payload_store[3], payload_store[4]};

  // Next state and result decode for the current word
  always_comb begin
    byte_position_next = byte_position;
    frame_type_next    = frame_type;
    pay_we             = 1'b0;
    res_valid          = 1'b0;
    res                = '0;
    if (in_take) begin
      if (byte_position == cfp_pkg::POS_HEAD) begin
        if (in_byte == cfp_pkg::HEAD_BYTE) byte_position_next = cfp_pkg::POS_TYPE;
      end else if (byte_position == cfp_pkg::POS_TYPE) begin
        // unknown type bytes keep us waiting at the type position
        if (in_byte >= cfp_pkg::TYPE_TASK && in_byte <= cfp_pkg::TYPE_POS) begin
          frame_type_next    = 3'(in_byte - cfp_pkg::TYPE_TASK) + cfp_pkg::FT_TASK;
          byte_position_next = cfp_pkg::POS_PAYLOAD;
        end
      end else if (tail == 3'd0 || byte_position > tail) begin
        byte_position_next = cfp_pkg::POS_HEAD;
        frame_type_next    = cfp_pkg::FT_NONE;
      end else if (byte_position < tail) begin
        pay_we             = 1'b1;
        byte_position_next = byte_position + 3'd1;
      end else begin
        // tail position: emit on a good tail, restart either way
        byte_position_next = cfp_pkg::POS_HEAD;
        frame_type_next    = cfp_pkg::FT_NONE;
        if (in_byte == cfp_pkg::TAIL_BYTE) begin
          res_valid       = 1'b1;
          res.frame_kind  = 2'(frame_type - cfp_pkg::FT_TASK);
          res.first_value = payload_store[0];
          if (frame_type == cfp_pkg::FT_TARGET) begin
            res.target_first  = payload_store[1];
            res.target_second = payload_store[2];
          end else if (frame_type == cfp_pkg::FT_POS) begin
            res.pos_x = {payload_store[1], payload_store[2]};
            res.pos_y = y_raw - y_offset;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= cfp_pkg::POS_HEAD;
      frame_type    <= cfp_pkg::FT_NONE;
    end else begin
      byte_position <= byte_position_next;
      frame_type    <= frame_type_next;
    end
  end

  // Payload bytes, no reset
  always_ff @(posedge clk) begin
    if (pay_we) payload_store[pay_idx] <= in_byte;
  end

endmodule

`default_nettype wire

>>> rtl/core/cfp_out_stage.sv
// Result register with a skid slot so input flow continues under output stall.
`default_nettype none

module cfp_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cfp_pkg::res_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cfp_pkg::res_t      out_data
);

  logic          skid_valid;
  cfp_pkg::res_t skid_data;
  logic          out_free;

  // The output register frees up when empty or taken this cycle
  assign out_free = !out_valid || out_ready;
  assign can_push = !skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end
    if (push && (skid_valid || !out_free)) skid_data <= push_data;
  end

endmodule

`default_nettype wire

>>> rtl/core/command_frame_parser_unit.sv
// Top level of the command frame parser: ports, offset register, parser and output stage.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  s_*      | in        | received byte, one per word
//  m_*      | out       | decoded frame: kind, first value, target bytes, X, Y
//  cfg_*    | in        | y_offset, 16-bit signed, reset value 30
//
// One byte is taken per cycle while s_tready is high; a frame's result, decoded on its
// tail byte, is registered in the output register, or in a one-word skid slot that
// lets input keep flowing while the output is stalled; s_tready drops only when both hold data.
// Synchronous reset returns the parser to hunting for the header byte.
`default_nettype none

module command_frame_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [cfp_pkg::OUT_DATA_W-1:0] m_tdata,
                                      // [1:0] frame_kind, [9:2] first_value,
                                      // [17:10] target_first, [25:18] target_second,
                                      // [41:26] pos_x, [57:42] pos_y, [63:58] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // y_offset
);

  logic          in_take;
  logic          res_valid;
  cfp_pkg::res_t res;
  cfp_pkg::res_t out_res;
  logic [15:0]   y_offset;

  assign in_take   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Y offset register
  always_ff @(posedge clk) begin
    if (rst) y_offset <= cfp_pkg::Y_OFFSET_RESET;
    else if (cfg_valid) y_offset <= cfg_data;
  end

  cfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_byte   (s_tdata),
    .y_offset  (y_offset),
    .res_valid (res_valid),
    .res       (res)
  );

  cfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack the output word, first field lowest
  assign m_tdata = {6'b0, out_res.pos_y, out_res.pos_x, out_res.target_second,
                    out_res.target_first, out_res.first_value, out_res.frame_kind};

endmodule

`default_nettype wire
